// ===== rtl/core/led_dimmer_ramp_with_exp_curve_macros.svh =====
// assertion macros used by the checker file ldr_exp_checker.sv
`ifndef LED_DIMMER_RAMP_WITH_EXP_CURVE_MACROS_SVH
`define LED_DIMMER_RAMP_WITH_EXP_CURVE_MACROS_SVH

// same-cycle implication, checked out of reset
`define LDR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ldr_exp: same-cycle check failed");

// next-cycle implication, checked out of reset
`define LDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ldr_exp: next-cycle check failed");

`endif

// ===== rtl/core/ldr_exp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ldr_exp_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned LevelMaxDefault = 100;

  localparam int unsigned LVL_W      = 7;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned DUTY_W     = 8;

  localparam logic [LVL_W-1:0] ROM_TOP      = 7'd100;
  localparam logic [LVL_W-1:0] ON_THRESHOLD = 7'd49;
  localparam logic [DUR_W-1:0] DUR_RESET    = 16'd2000;

  // output tdata layout
  localparam int unsigned OUT_DUTY_LSB  = 0;
  localparam int unsigned OUT_PIN_BIT   = 8;
  localparam int unsigned OUT_LVL_LSB   = 9;
  localparam int unsigned OUT_RAMP_BIT  = 16;

  typedef enum logic {
    CMD_SET_TARGET = 1'b0,
    CMD_TICK       = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_DURATION = 2'd0,
    REG_DIGITAL_MODE  = 2'd1,
    REG_OUT_INVERTED  = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  // floor(1.05697667^n), ends forced to 0 and 255
  localparam logic [DUTY_W-1:0] DUTY_ROM [0:100] = '{
    8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,
    8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,
    8'd9,   8'd9,   8'd10,  8'd10,  8'd11,  8'd12,  8'd12,  8'd13,  8'd14,  8'd15,
    8'd15,  8'd16,  8'd17,  8'd18,  8'd19,  8'd21,  8'd22,  8'd23,  8'd24,  8'd26,
    8'd27,  8'd29,  8'd31,  8'd32,  8'd34,  8'd36,  8'd38,  8'd40,  8'd43,  8'd45,
    8'd48,  8'd51,  8'd54,  8'd57,  8'd60,  8'd63,  8'd67,  8'd71,  8'd75,  8'd79,
    8'd84,  8'd88,  8'd94,  8'd99,  8'd105, 8'd111, 8'd117, 8'd124, 8'd131, 8'd138,
    8'd146, 8'd154, 8'd163, 8'd173, 8'd182, 8'd193, 8'd204, 8'd215, 8'd228, 8'd241,
    8'd255
  };

endpackage

`default_nettype wire

// ===== rtl/core/led_dimmer_ramp_with_exp_curve.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser: command, tdata: target_level
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: duty, pin, level, ramping
// cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// a tick or an immediate jump goes through ST_DONE, which waits for a free result register
// a fade start runs a restoring divider, one quotient bit a cycle
// one item is worked on at a time
// the result register frees the input side: a new item is taken while a result waits
// reset clears level, goal and step and loads the register defaults (duration 2000)
// cfg_ready_o is always high

module led_dimmer_ramp_with_exp_curve #(
  parameter int unsigned FRAC_BITS = ldr_exp_pkg::FracBitsDefault,
  parameter int unsigned LEVEL_MAX = ldr_exp_pkg::LevelMaxDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [ldr_exp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [6:0] target_level, [7] zero
  input  wire logic                                s_axis_tuser,  // [0] command
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [7:0] pwm_duty, [8] pin_level, [15:9] current_level, [16] ramping, [23:17] zero
  output logic [ldr_exp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ldr_exp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ldr_exp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ldr_exp_pkg::*;

  localparam int unsigned ACC_W = LVL_W + FRAC_BITS;
  localparam int unsigned DIV_W = ACC_W;
  localparam int unsigned CNT_W = $clog2(DIV_W);
  localparam logic [LVL_W-1:0] LvlMax = LVL_W'(LEVEL_MAX);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [DUR_W-1:0] dur_q;
  logic             digital_q;
  logic             inverted_q;

  logic [LVL_W-1:0] goal_q, goal_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] step_mag_q, step_mag_d;
  logic             step_neg_q, step_neg_d;

  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DUR_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic             in_xfer;
  logic [LVL_W-1:0] tgt_raw, tgt_sat, lvl_now, lvl_diff;
  logic [ACC_W-1:0] goal_fix, tgt_fix, lvl_fix;
  logic [ACC_W:0]   tick_sum, tick_dif;
  logic [DUR_W:0]   rem_shift;
  logic             rem_ge;
  logic [DUR_W-1:0] rem_sub;
  logic [DIV_W-1:0] quot_next;
  logic [LVL_W-1:0] rom_idx;
  logic [DUTY_W-1:0] duty;
  logic             out_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = ~out_valid_q | m_axis_tready;

  assign tgt_raw  = s_axis_tdata[LVL_W-1:0];
  assign tgt_sat  = (tgt_raw > LvlMax) ? LvlMax : tgt_raw;
  assign lvl_now  = acc_q[ACC_W-1:FRAC_BITS];
  assign goal_fix = {goal_q, {FRAC_BITS{1'b0}}};
  assign tgt_fix  = {tgt_sat, {FRAC_BITS{1'b0}}};
  assign lvl_fix  = {lvl_now, {FRAC_BITS{1'b0}}};
  assign lvl_diff = (tgt_sat > lvl_now) ? (tgt_sat - lvl_now) : (lvl_now - tgt_sat);

  assign tick_sum = {1'b0, acc_q} + {1'b0, step_mag_q};
  assign tick_dif = {1'b0, acc_q} - {1'b0, step_mag_q};

  // restoring divider, one quotient bit a cycle
  assign rem_shift = {rem_q, dvd_q[DIV_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dur_q});
  assign rem_sub   = rem_shift[DUR_W-1:0] - dur_q;
  assign quot_next = {dvd_q[DIV_W-2:0], rem_ge};

  assign rom_idx = (lvl_now > ROM_TOP) ? ROM_TOP : lvl_now;
  assign duty    = digital_q ? '0 : DUTY_ROM[rom_idx];

  always_comb begin
    state_d     = state_q;
    goal_d      = goal_q;
    acc_d       = acc_q;
    step_mag_d  = step_mag_q;
    step_neg_d  = step_neg_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_DONE;
          if (s_axis_tuser == CMD_SET_TARGET) begin
            if (tgt_sat != goal_q) begin
              goal_d = tgt_sat;
              if ((dur_q == '0) || digital_q) begin
                acc_d      = tgt_fix;
                step_mag_d = '0;
              end else begin
                acc_d = lvl_fix;
                if (lvl_now == tgt_sat) begin
                  step_mag_d = '0;
                end else begin
                  step_neg_d = (tgt_sat < lvl_now);
                  dvd_d      = {lvl_diff, {FRAC_BITS{1'b0}}};
                  rem_d      = '0;
                  cnt_d      = '0;
                  state_d    = ST_DIV;
                end
              end
            end
          end else if (lvl_now != goal_q) begin
            if (step_mag_q == '0) begin
              acc_d = goal_fix;
            end else if (!step_neg_q) begin
              acc_d = (tick_sum > {1'b0, goal_fix}) ? goal_fix : tick_sum[ACC_W-1:0];
            end else begin
              // clamp on underflow or on passing the goal
              acc_d = (tick_dif[ACC_W] || (tick_dif[ACC_W-1:0] < goal_fix)) ?
                      goal_fix : tick_dif[ACC_W-1:0];
            end
          end
        end
      end
      ST_DIV: begin
        dvd_d = quot_next;
        rem_d = rem_ge ? rem_sub : rem_shift[DUR_W-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          step_mag_d = (quot_next == '0) ? ACC_W'(1) : quot_next;
          state_d    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[OUT_DUTY_LSB +: DUTY_W] = duty;
          out_data_d[OUT_PIN_BIT]            = (lvl_now > ON_THRESHOLD) ^ inverted_q;
          out_data_d[OUT_LVL_LSB +: LVL_W]   = lvl_now;
          out_data_d[OUT_RAMP_BIT]           = (lvl_now != goal_q);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      goal_q      <= '0;
      acc_q       <= '0;
      step_mag_q  <= '0;
      step_neg_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      goal_q      <= goal_d;
      acc_q       <= acc_d;
      step_mag_q  <= step_mag_d;
      step_neg_q  <= step_neg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q      <= DUR_RESET;
      digital_q  <= 1'b0;
      inverted_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RAMP_DURATION: dur_q      <= cfg_data_i[DUR_W-1:0];
        REG_DIGITAL_MODE:  digital_q  <= cfg_data_i[0];
        REG_OUT_INVERTED:  inverted_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ldr_exp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "led_dimmer_ramp_with_exp_curve_macros.svh"

module ldr_exp_checker #(
  parameter int unsigned LEVEL_MAX = ldr_exp_pkg::LevelMaxDefault
) (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  // [7:0] pwm_duty, [8] pin_level, [15:9] current_level, [16] ramping
  input wire logic [ldr_exp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ldr_exp_pkg::*;

  localparam logic [LVL_W-1:0] LvlMax = LVL_W'(LEVEL_MAX);

  logic [LVL_W-1:0]  out_lvl;
  logic [DUTY_W-1:0] out_duty;
  logic              in_xfer;

  assign out_lvl  = m_axis_tdata[OUT_LVL_LSB +: LVL_W];
  assign out_duty = m_axis_tdata[OUT_DUTY_LSB +: DUTY_W];
  assign in_xfer  = s_axis_tvalid & s_axis_tready;

  // a stalled result holds
  `LDR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  // the level never passes the top of the range
  `LDR_ASSERT_SAME(a_lvl_range, clk_i, rst_ni, m_axis_tvalid, out_lvl <= LvlMax)

  // a dark led has no duty
  `LDR_ASSERT_SAME(a_dark_duty, clk_i, rst_ni, m_axis_tvalid && (out_lvl == '0),
    out_duty == '0)

  // an item keeps the block busy for at least the next cycle
  `LDR_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, in_xfer, !s_axis_tready)

endmodule

bind led_dimmer_ramp_with_exp_curve ldr_exp_checker #(
  .LEVEL_MAX(LEVEL_MAX)
) u_ldr_exp_checker (.*);

`default_nettype wire

// ===== tb/ldr_dimmer_checker.sv =====
`timescale 1ns / 1ps

module ldr_dimmer_checker
  import ldr_exp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  logic                   in_user_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [OUT_TDATA_W-1:0] out_data_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o
);

  localparam int unsigned FRAC  = FracBitsDefault;
  localparam int unsigned ACC_W = LVL_W + FRAC;
  localparam logic [LVL_W-1:0] LVL_CAP = LVL_W'(LevelMaxDefault);

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              pin;
    logic [LVL_W-1:0]  level;
    logic              ramping;
  } dimmer_out_t;

  // register copies
  logic [DUR_W-1:0] fade_ms;
  logic             digital_on;
  logic             pin_invert;

  // brightness state, level held as unsigned fixed point
  logic [LVL_W-1:0] goal;
  logic [ACC_W-1:0] level_fix;
  logic [ACC_W-1:0] step_mag;
  logic             step_down;

  dimmer_out_t expected_q[$];
  dimmer_out_t got;
  dimmer_out_t want;
  int          fails = 0;
  int          checked = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, checked, msg);
    fails++;
  endtask

  function automatic dimmer_out_t advance_dimmer(input cmd_e cmd, input logic [LVL_W-1:0] raw);
    logic [LVL_W-1:0] tgt;
    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] diff;
    logic [ACC_W-1:0] goal_fix;
    logic [ACC_W:0]   sum;
    dimmer_out_t      res;
    tgt      = (raw > LVL_CAP) ? LVL_CAP : raw;
    lvl      = level_fix[ACC_W-1:FRAC];
    goal_fix = ACC_W'(goal) << FRAC;
    if (cmd == CMD_SET_TARGET) begin
      if (tgt != goal) begin
        goal = tgt;
        if (fade_ms == '0 || digital_on) begin
          level_fix = ACC_W'(tgt) << FRAC;
          step_mag  = '0;
        end else begin
          // fraction dropped before the step is worked out
          level_fix = ACC_W'(lvl) << FRAC;
          diff      = (goal > lvl) ? goal - lvl : lvl - goal;
          step_down = (goal < lvl);
          step_mag  = (ACC_W'(diff) << FRAC) / fade_ms;
          // a fade always moves by at least one lsb
          if (lvl != goal && step_mag == '0) step_mag = ACC_W'(1);
        end
      end
    end else if (lvl != goal) begin
      if (step_mag == '0) begin
        level_fix = goal_fix;
      end else if (!step_down) begin
        sum       = level_fix + step_mag;
        level_fix = (sum > goal_fix) ? goal_fix : sum[ACC_W-1:0];
      end else if (level_fix < step_mag || level_fix - step_mag < goal_fix) begin
        level_fix = goal_fix;
      end else begin
        level_fix = level_fix - step_mag;
      end
    end
    lvl         = level_fix[ACC_W-1:FRAC];
    res.duty    = digital_on ? '0 : DUTY_ROM[(lvl > ROM_TOP) ? ROM_TOP : lvl];
    res.pin     = (lvl > ON_THRESHOLD) ^ pin_invert;
    res.level   = lvl;
    res.ramping = (lvl != goal);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_ms    = DUR_RESET;
      digital_on = 1'b0;
      pin_invert = 1'b0;
      goal       = '0;
      level_fix  = '0;
      step_mag   = '0;
      step_down  = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {out_data_i[OUT_DUTY_LSB +: DUTY_W], out_data_i[OUT_PIN_BIT],
               out_data_i[OUT_LVL_LSB +: LVL_W], out_data_i[OUT_RAMP_BIT]};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %h arrived with nothing expected", out_data_i));
        end else begin
          want = expected_q.pop_front();
          if (got.duty !== want.duty)
            report_mismatch($sformatf("pwm_duty %0d, expected %0d", got.duty, want.duty));
          if (got.pin !== want.pin)
            report_mismatch($sformatf("pin_level %0b, expected %0b", got.pin, want.pin));
          if (got.level !== want.level)
            report_mismatch($sformatf("current_level %0d, expected %0d", got.level, want.level));
          if (got.ramping !== want.ramping)
            report_mismatch($sformatf("ramping %0b, expected %0b (level %0d)",
                                      got.ramping, want.ramping, want.level));
          checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_RAMP_DURATION: fade_ms    = cfg_data_i[DUR_W-1:0];
          REG_DIGITAL_MODE:  digital_on = cfg_data_i[0];
          REG_OUT_INVERTED:  pin_invert = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(advance_dimmer(cmd_e'(in_user_i), in_data_i[LVL_W-1:0]));
      pending_o <= expected_q.size();
    end
    fail_count_o <= fails;
    checked_o    <= checked;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ldr_exp_pkg::*;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 148;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 40;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int fail_count;
  int pending_results;
  int results_checked;
  int items_sent = 0;
  int rx_holds_asked = 0;
  int rx_holds_done = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  always #5ns clk_i = ~clk_i;

  led_dimmer_ramp_with_exp_curve dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ldr_dimmer_checker dimmer_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .checked_o    (results_checked)
  );

  // valid stays high across back-to-back transfers, it only drops for a gap or in drain()
  task automatic send_item(input cmd_e cmd, input logic [LVL_W-1:0] tgt);
    if (!calm && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(3) == 0) repeat ($urandom_range(6, 30)) @(posedge clk_i);
      else repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, tgt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) send_item(CMD_TICK, LVL_W'($urandom));
    else if (pick < 93) send_item(CMD_SET_TARGET, LVL_W'($urandom_range(0, 100)));
    else send_item(CMD_SET_TARGET, LVL_W'($urandom_range(101, 127)));
  endtask

  // sender stops until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // one-bit registers get noise in the upper bits, only bit 0 counts
  task automatic program_regs(input logic [DUR_W-1:0] dur, input logic dig, input logic inv);
    cfg_write(REG_RAMP_DURATION, dur);
    cfg_write(REG_DIGITAL_MODE, {15'($urandom), dig});
    cfg_write(REG_OUT_INVERTED, {15'($urandom), inv});
    cfg_write(REG_UNUSED, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random back-pressure, plus long hold-offs on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_holds_asked != rx_holds_done) begin
        rx_holds_done++;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results);
      $display("FAIL led_dimmer_ramp_with_exp_curve");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [DUR_W-1:0] dur;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SET_TARGET;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_RAMP_DURATION;
    cfg_data_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: slow fade, target above the cap, same target, fade start at goal
    send_item(CMD_SET_TARGET, 7'd127);
    send_item(CMD_TICK, 7'd0);
    send_item(CMD_TICK, 7'd127);
    send_item(CMD_SET_TARGET, 7'd100);
    send_item(CMD_TICK, 7'd0);
    send_item(CMD_SET_TARGET, 7'd0);
    send_item(CMD_TICK, 7'd0);
    drain();

    // short fade: exact steps, restart on the current level, clamp at both ends
    program_regs(16'd4, 1'b0, 1'b0);
    send_item(CMD_SET_TARGET, 7'd100);
    repeat (2) send_item(CMD_TICK, 7'd0);
    send_item(CMD_SET_TARGET, 7'd50);
    send_item(CMD_TICK, 7'd0);
    send_item(CMD_SET_TARGET, 7'd100);
    repeat (5) send_item(CMD_TICK, 7'd85);
    send_item(CMD_SET_TARGET, 7'd0);
    repeat (5) send_item(CMD_TICK, 7'd42);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph % 6)
        0: dur = '0;
        1: dur = 16'd1;
        2: dur = 16'($urandom_range(2, 16));
        3: dur = 16'hFFFF;
        4: dur = 16'($urandom_range(17, 300));
        default: dur = 16'($urandom);
      endcase
      program_regs(dur, (ph % 4) == 3, (ph % 3) == 2);
      calm = (ph == 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ((ph == 2 || ph == 8) && i == 30) rx_holds_asked++;
        send_random_item();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("sent %0d items over %0d register settings, %0d results compared",
             items_sent, NUM_PHASES + 2, results_checked);
    $display("output hold-offs: %0d, mismatches: %0d", rx_holds_done, fail_count);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS led_dimmer_ramp_with_exp_curve");
    end else begin
      $display("FAIL led_dimmer_ramp_with_exp_curve");
    end
    $finish;
  end

endmodule
